### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define TCGW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define TCGW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tcgw_pkg.sv
// shared types and constants for the text console glyph writer
package tcgw_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int CELL_ROWS   = 16;
  localparam int CELL_WIDTH  = 8;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(CELL_ROWS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_LINE_STRIDE  = 2'd1;
  localparam logic [1:0] REG_FG_COLOR     = 2'd2;
  localparam logic [1:0] REG_CLEAR_COLOR  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] glyph_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_index;
    logic [7:0]  pixel_mask;
    logic [31:0] pixel_value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [13:0] line_stride;
    logic [31:0] fg_color;
    logic [31:0] clear_color;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             setup;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] rd_row;
    logic             last;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cell_req;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/tcgw_ctrl.sv
// sequencer for the sixteen row writes of one cell
module tcgw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcgw_pkg::dp_stat_t  stat,
  output tcgw_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS
  } state_t;

  state_t                     state_r, state_nxt;
  logic [tcgw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                       accept;
  logic                       emit;
  logic                       last_row;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign emit     = (state_r == ST_ROWS) && stat.out_free;
  assign last_row = (row_r == tcgw_pkg::ROW_W'(tcgw_pkg::CELL_ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        row_nxt = '0;
        if (accept && stat.cell_req) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (emit) begin
          row_nxt = row_r + 1'b1;
          if (last_row) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  always_comb begin
    cmd.accept = accept;
    cmd.setup  = (state_r == ST_SETUP);
    cmd.emit   = emit;
    cmd.row    = row_r;
    // keep the read one row ahead only when the current row leaves
    cmd.rd_row = emit ? row_r + 1'b1 : row_r;
    cmd.last   = last_row;
  end

endmodule

### rtl/tcgw_datapath.sv
// cursor, glyph store, address arithmetic and output register
module tcgw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcgw_pkg::cfg_t      cfg,
  input  tcgw_pkg::in_t       in_data,
  input  tcgw_pkg::ctl_cmd_t  cmd,
  output tcgw_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output tcgw_pkg::out_t      out_data
);

  logic [7:0]  glyph_mem [tcgw_pkg::STORE_DEPTH];

  logic [12:0] cur_x_r, cur_x_nxt;
  logic [15:0] cur_y_r, cur_y_nxt;
  logic [15:0] row_y_r, row_y_nxt;
  logic [31:0] xoff_r, xoff_nxt;
  logic [7:0]  code_r;
  logic        erase_r;
  logic [31:0] rowacc_r;
  logic [29:0] prod;
  logic [7:0]  rd_data_r;
  logic        out_valid_r;
  tcgw_pkg::out_t out_r;

  logic        is_draw, is_erase, is_load, is_newline;
  logic [12:0] xe;
  logic [15:0] ye;
  logic [13:0] nx;
  logic [7:0]  mask;

  function automatic logic [15:0] line_up(input logic [15:0] y);
    line_up = (y < 16'd16) ? 16'd0 : y - 16'd16;
  endfunction

  assign is_draw    = (in_data.cmd == tcgw_pkg::CMD_DRAW);
  assign is_erase   = (in_data.cmd == tcgw_pkg::CMD_ERASE);
  assign is_load    = (in_data.cmd == tcgw_pkg::CMD_LOAD);
  assign is_newline = is_draw && (in_data.char_code == tcgw_pkg::NEWLINE_CODE);

  assign stat.cell_req = (is_draw && !is_newline) || is_erase;
  assign stat.out_free = !out_valid_r || !out_stall;

  // erase at the left edge first jumps to the end of the line above
  assign xe = (cur_x_r == 13'd0) ? cfg.screen_width : cur_x_r;
  assign ye = (cur_x_r == 13'd0) ? line_up(cur_y_r) : cur_y_r;
  assign nx = {1'b0, cur_x_r} + 14'(tcgw_pkg::CELL_WIDTH);

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    row_y_nxt = row_y_r;
    xoff_nxt  = xoff_r;
    if (cmd.accept) begin
      if (is_newline) begin
        cur_x_nxt = '0;
        cur_y_nxt = cur_y_r + 16'd16;
      end else if (is_draw) begin
        xoff_nxt  = {19'd0, cur_x_r};
        row_y_nxt = cur_y_r;
        if (({1'b0, nx} + 15'(tcgw_pkg::CELL_WIDTH)) > {2'b00, cfg.screen_width}) begin
          cur_x_nxt = '0;
          cur_y_nxt = cur_y_r + 16'd16;
        end else begin
          cur_x_nxt = nx[12:0];
        end
      end else if (is_erase) begin
        xoff_nxt  = {19'd0, xe} - 32'(tcgw_pkg::CELL_WIDTH);
        row_y_nxt = ye;
        if (xe < 13'(tcgw_pkg::CELL_WIDTH)) begin
          cur_x_nxt = cfg.screen_width;
          cur_y_nxt = line_up(ye);
        end else begin
          cur_x_nxt = xe - 13'(tcgw_pkg::CELL_WIDTH);
          cur_y_nxt = ye;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_y_r <= row_y_nxt;
    xoff_r  <= xoff_nxt;
    if (cmd.accept) begin
      code_r  <= in_data.char_code;
      erase_r <= is_erase;
    end
  end

  // glyph store: one write port for loads, one registered read port for rows
  always_ff @(posedge clk) begin
    if (cmd.accept && is_load && (in_data.glyph_row < tcgw_pkg::GLYPH_ROWS)) begin
      glyph_mem[tcgw_pkg::STORE_AW'(in_data.char_code * tcgw_pkg::GLYPH_ROWS
                                    + in_data.glyph_row)] <= in_data.glyph_bits;
    end
    rd_data_r <= glyph_mem[tcgw_pkg::STORE_AW'(code_r * tcgw_pkg::GLYPH_ROWS + cmd.rd_row)];
  end

  // row base: one multiply at setup, then one stride add per row
  assign prod = row_y_r * cfg.line_stride;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rowacc_r <= {2'b00, prod};
    end else if (cmd.emit) begin
      rowacc_r <= rowacc_r + {18'd0, cfg.line_stride};
    end
  end

  always_comb begin
    if (erase_r) begin
      mask = 8'hff;
    end else if (cmd.row < tcgw_pkg::GLYPH_ROWS) begin
      mask = rd_data_r;
    end else begin
      mask = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.pixel_index <= xoff_r + rowacc_r;
      out_r.pixel_mask  <= mask;
      out_r.pixel_value <= erase_r ? cfg.clear_color : cfg.fg_color;
      out_r.last        <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/text_console_glyph_writer.sv
// top level of the text console glyph writer: register port and block wiring
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   tcgw_pkg::in_t  (cmd, char_code, glyph_row, glyph_bits)
//  out      output     out_valid/out_stall tcgw_pkg::out_t (pixel_index, mask, value, last)
//  cfg      input      psel/penable/pready screen_width, line_stride, fg_color, clear_color
//
// a load, a newline or an unknown command leaves the block idle and ready for the next request
// a draw or an erase first passes a setup state for the row-base multiply, then sixteen row
// writes, one per cycle while out does not stall, each a glyph store read and a stride add
// a stall on the out channel holds the row sequencer; in_stall is high while a cell is busy
// reset clears the cursor and loads the config register defaults; the glyph store is undefined until loaded
`include "assert_macros.svh"

module text_console_glyph_writer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tcgw_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tcgw_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  tcgw_pkg::cfg_t      cfg_r;
  tcgw_pkg::ctl_cmd_t  ctl_cmd;
  tcgw_pkg::dp_stat_t  dp_stat;
  logic                cfg_wr;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width <= 13'd1024;
      cfg_r.line_stride  <= 14'd1024;
      cfg_r.fg_color     <= 32'hffff_ffff;
      cfg_r.clear_color  <= 32'h0000_0000;
    end else if (cfg_wr) begin
      case (reg_idx)
        tcgw_pkg::REG_SCREEN_WIDTH: cfg_r.screen_width <= pwdata[12:0];
        tcgw_pkg::REG_LINE_STRIDE:  cfg_r.line_stride  <= pwdata[13:0];
        tcgw_pkg::REG_FG_COLOR:     cfg_r.fg_color     <= pwdata;
        tcgw_pkg::REG_CLEAR_COLOR:  cfg_r.clear_color  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tcgw_pkg::REG_SCREEN_WIDTH: prdata = {19'd0, cfg_r.screen_width};
      tcgw_pkg::REG_LINE_STRIDE:  prdata = {18'd0, cfg_r.line_stride};
      tcgw_pkg::REG_FG_COLOR:     prdata = cfg_r.fg_color;
      tcgw_pkg::REG_CLEAR_COLOR:  prdata = cfg_r.clear_color;
      default:                    prdata = 32'd0;
    endcase
  end

  tcgw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  tcgw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a row is never loaded over a pending result
  `TCGW_ASSERT_SAME(a_emit_free, clk, rst_n, ctl_cmd.emit, dp_stat.out_free)
  // a cell request keeps the input stalled in the following cycle
  `TCGW_ASSERT_NEXT(a_cell_busy, clk, rst_n, ctl_cmd.accept && dp_stat.cell_req, in_stall)
  // after the final row is loaded the block takes requests again
  `TCGW_ASSERT_NEXT(a_last_idle, clk, rst_n, ctl_cmd.emit && ctl_cmd.last, !in_stall)
  // every emitted row shows up as a valid result
  `TCGW_ASSERT_NEXT(a_emit_valid, clk, rst_n, ctl_cmd.emit, out_valid)

endmodule

### tb/sv/tb.sv
// self-checking testbench for the text console glyph writer
module tb;
  import tcgw_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int HOLD_CYCLES = 500;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_glyph_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // console state as the block should hold it
  logic [12:0] scr_w = 13'd1024;
  logic [13:0] stride = 14'd1024;
  logic [31:0] fg = 32'hFFFF_FFFF;
  logic [31:0] clr = 32'h0;
  logic [12:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic [7:0]  glyph_mem [STORE_DEPTH];
  out_t        row_writes_due [$];

  // stimulus side bookkeeping
  in_t         req_backlog [$];
  bit [15:0]   rows_loaded [GLYPH_COUNT];
  logic [7:0]  drawable [$];
  int          n_queued = 0;
  int          n_acc = 0;
  int          n_writes = 0;
  int          n_fail = 0;
  int          cfg_writes = 0;

  function automatic void step_console(in_t req);
    out_t        w;
    logic [31:0] nx;
    case (req.cmd)
      CMD_LOAD: glyph_mem[{req.char_code, req.glyph_row}] = req.glyph_bits;
      CMD_DRAW: begin
        if (req.char_code == NEWLINE_CODE) begin
          cur_x = '0;
          cur_y = cur_y + 16'd16;
        end else begin
          for (int r = 0; r < CELL_ROWS; r++) begin
            w.pixel_index = 32'(cur_x) + (32'(cur_y) + 32'(r)) * 32'(stride);
            w.pixel_mask  = glyph_mem[{req.char_code, 4'(r)}];
            w.pixel_value = fg;
            w.last        = (r == CELL_ROWS - 1);
            row_writes_due.push_back(w);
          end
          nx = 32'(cur_x) + CELL_WIDTH;
          if (nx + CELL_WIDTH > 32'(scr_w)) begin
            cur_x = '0;
            cur_y = cur_y + 16'd16;
          end else begin
            cur_x = nx[12:0];
          end
        end
      end
      CMD_ERASE: begin
        // step back onto the end of the line above, row held at the top
        if (cur_x == '0) begin
          cur_x = scr_w;
          cur_y = (cur_y < 16'd16) ? 16'd0 : cur_y - 16'd16;
        end
        for (int r = 0; r < CELL_ROWS; r++) begin
          w.pixel_index = 32'(cur_x) - CELL_WIDTH + (32'(cur_y) + 32'(r)) * 32'(stride);
          w.pixel_mask  = 8'hFF;
          w.pixel_value = clr;
          w.last        = (r == CELL_ROWS - 1);
          row_writes_due.push_back(w);
        end
        if (cur_x < CELL_WIDTH) begin
          cur_x = scr_w;
          cur_y = (cur_y < 16'd16) ? 16'd0 : cur_y - 16'd16;
        end else begin
          cur_x = cur_x - 13'(CELL_WIDTH);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] c, logic [7:0] code, logic [3:0] row,
                                    logic [7:0] bits);
    in_t q;
    q.cmd        = c;
    q.char_code  = code;
    q.glyph_row  = row;
    q.glyph_bits = bits;
    req_backlog.push_back(q);
    n_queued++;
    // a glyph may only be drawn once all of its rows hold data
    if (c == CMD_LOAD && rows_loaded[code] != 16'hFFFF) begin
      rows_loaded[code][row] = 1'b1;
      if (rows_loaded[code] == 16'hFFFF) drawable.push_back(code);
    end
  endfunction

  function automatic void queue_random_req();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 6 || drawable.size() == 0) begin
      case ($urandom_range(0, 3))
        0: code = 8'h00;
        1: code = 8'hFF;
        2: code = NEWLINE_CODE;
        default: code = 8'($urandom);
      endcase
      for (int r = 0; r < GLYPH_ROWS; r++)
        queue_req(CMD_LOAD, code, 4'(r),
                  ($urandom_range(0, 7) == 0) ? (($urandom & 1) ? 8'hFF : 8'h00)
                                              : 8'($urandom));
    end else if (pick < 14) begin
      queue_req(CMD_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
    end else if (pick < 58) begin
      queue_req(CMD_DRAW, drawable[$urandom_range(0, drawable.size() - 1)],
                4'($urandom), 8'($urandom));
    end else if (pick < 68) begin
      queue_req(CMD_DRAW, NEWLINE_CODE, 4'($urandom), 8'($urandom));
    end else if (pick < 94) begin
      queue_req(CMD_ERASE, 8'($urandom), 4'($urandom), 8'($urandom));
    end else begin
      queue_req(CMD_NONE, 8'($urandom), 4'($urandom), 8'($urandom));
    end
  endfunction

  task automatic add_random(int n);
    int target;
    target = n_queued + n;
    while (n_queued < target) queue_random_req();
  endtask

  // wait until every request is taken and every row write has come back
  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || row_writes_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH: scr_w = val[12:0];
      REG_LINE_STRIDE:  stride = val[13:0];
      REG_FG_COLOR:     fg = val;
      REG_CLEAR_COLOR:  clr = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] s, logic [31:0] f, logic [31:0] c);
    set_reg(REG_SCREEN_WIDTH, w);
    set_reg(REG_LINE_STRIDE, s);
    set_reg(REG_FG_COLOR, f);
    set_reg(REG_CLEAR_COLOR, c);
    @(negedge clk);
  endtask

  // request driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_console(in_data);
        n_acc++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise stall modes that change now and then
  int hold_left = 0;
  bit held = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && n_acc >= 30) begin
      held      <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (mode_left % 8) < 5;
      endcase
    end
  end

  // row write checker
  always @(posedge clk) begin : mon
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_writes++;
      if (row_writes_due.size() == 0) begin
        $error("row write with none due: %p", out_data);
        n_fail++;
      end else begin
        want = row_writes_due.pop_front();
        if (out_data.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %h, got %h", want.pixel_index, out_data.pixel_index);
          n_fail++;
        end
        if (out_data.pixel_mask !== want.pixel_mask) begin
          $error("pixel_mask: expected %h, got %h", want.pixel_mask, out_data.pixel_mask);
          n_fail++;
        end
        if (out_data.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %h, got %h", want.pixel_value, out_data.pixel_value);
          n_fail++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          n_fail++;
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL text_console_glyph_writer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: erase at the origin keeps the row at the top
    queue_req(CMD_ERASE, 8'h00, 4'h0, 8'h00);
    for (int r = 0; r < GLYPH_ROWS; r++)
      queue_req(CMD_LOAD, 8'hFF, 4'(r), r[3] ? ~(8'h01 << r[2:0]) : (8'h80 >> r[2:0]));
    queue_req(CMD_DRAW, 8'hFF, 4'hF, 8'hFF);
    queue_req(CMD_DRAW, NEWLINE_CODE, 4'h0, 8'h00);
    // erase from column 0 wraps to the end of the line above
    queue_req(CMD_ERASE, 8'hFF, 4'hF, 8'hFF);
    queue_req(CMD_ERASE, 8'h00, 4'h0, 8'h00);
    queue_req(CMD_NONE, 8'hFF, 4'hF, 8'hFF);
    queue_req(CMD_DRAW, 8'hFF, 4'h0, 8'h00);
    drain();

    // narrowest screen: every draw wraps
    configure(32'd8, 32'd8, 32'h0, 32'hFFFF_FFFF);
    add_random(40);
    drain();

    configure(32'd4096, 32'd8192, $urandom, $urandom);
    add_random(40);
    drain();

    // width not a multiple of the cell: erase runs below column 0
    configure(32'd13, 32'd8191, $urandom, $urandom);
    queue_req(CMD_DRAW, NEWLINE_CODE, 4'h0, 8'h00);
    repeat (4) queue_req(CMD_ERASE, 8'($urandom), 4'($urandom), 8'($urandom));
    queue_req(CMD_DRAW, 8'hFF, 4'($urandom), 8'($urandom));
    repeat (2) queue_req(CMD_ERASE, 8'($urandom), 4'($urandom), 8'($urandom));
    add_random(20);
    drain();

    // a run of newlines pushes the cursor well down the screen
    configure(32'd1024, 32'd8192, $urandom, $urandom);
    repeat (24)
      queue_req(CMD_DRAW, NEWLINE_CODE, 4'($urandom), 8'($urandom));
    add_random(16);
    drain();

    repeat (3) begin
      configure($urandom_range(8, 4096), $urandom_range(8, 8192), $urandom, $urandom);
      add_random(40);
      drain();
    end

    $display("covered %0d requests, %0d row writes and %0d register writes", n_acc, n_writes,
             cfg_writes);
    $display("screen widths 8, 13, 1024 and 4096, strides 8 to 8192, long hold-off, drains");
    if (n_fail == 0) begin
      $display("PASS text_console_glyph_writer");
    end else begin
      $display("FAIL text_console_glyph_writer");
    end
    $finish;
  end

endmodule
